@@ rtl/utf8d_pkg.sv @@
// Shared constants, types and lead-byte helper for the UTF-8 code point decoder.
package utf8d_pkg;

	localparam int BYTE_W = 8;
	localparam int CP_W   = 21;
	localparam int CNT_W  = 2;
	localparam int LEN_W  = 3;
	localparam int HOLD_DEPTH = 3;

	localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

	localparam logic [LEN_W-1:0] LEN_NONE  = 3'd0;
	localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
	localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
	localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [CP_W-1:0]   cp_t;

	// Total sequence length opened by a lead byte, LEN_NONE if not a lead.
	function automatic logic [LEN_W-1:0] seq_len(input byte_t b);
		logic [LEN_W-1:0] len;
		len = LEN_NONE;
		if ((b & 8'hE0) == 8'hC0)
			len = LEN_TWO;
		else if ((b & 8'hF0) == 8'hE0)
			len = LEN_THREE;
		else if ((b & 8'hF8) == 8'hF0)
			len = LEN_FOUR;
		return len;
	endfunction

endpackage

@@ rtl/utf8_codepoint_decoder.sv @@
// Lenient UTF-8 byte stream to code point decoder, top level.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+----------------------------------
//   in      | sink      | in_valid, in_stall  | data_byte, end_of_text
//   out     | source    | out_valid, out_stall| code_point, substituted, last
//
// Each accepted word is decoded in the cycle it is taken; its results land in
// a result register in the next cycle. Plain text, whose words give zero or
// one result each, runs at one byte per cycle while out_stall is low. A broken
// sequence or a flush gives up to three replacement words plus one tail word;
// these drain one per cycle while out_stall is low, and in_stall is held until
// the last leaves (or is leaving). Reset clears the held count, replacement
// count and tail flag; held bytes, only read once written, are not reset.
module utf8_codepoint_decoder
	import utf8d_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// input byte channel
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic             end_of_text,
	// code point channel
	output logic             out_valid,
	input  logic             out_stall,
	output logic [CP_W-1:0]  code_point,
	output logic             substituted,
	output logic             last
);

	// Decoder state: held lead and continuation bytes and how many are held.
	byte_t            held_q [HOLD_DEPTH];
	logic [CNT_W-1:0] held_cnt_q;

	// Result register: pending replacement count, then one optional tail word.
	logic [CNT_W-1:0] flush_cnt_s1;
	logic             tail_vld_s1;
	cp_t              tail_cp_s1;
	logic             tail_sub_s1;

	logic in_fire, out_fire, bundle_empty, draining_last;

	// ------------------------------------------------------------------
	// Output side: replacements for the flushed bytes go first, tail last.
	// ------------------------------------------------------------------
	assign bundle_empty = (flush_cnt_s1 == '0) && !tail_vld_s1;
	assign out_valid    = !bundle_empty;

	always_comb begin
		if (flush_cnt_s1 != '0) begin
			code_point  = REPLACEMENT_CP;
			substituted = 1'b1;
			last        = (flush_cnt_s1 == CNT_W'(1)) && !tail_vld_s1;
		end else begin
			code_point  = tail_cp_s1;
			substituted = tail_sub_s1;
			last        = 1'b1;
		end
	end

	assign out_fire      = out_valid && !out_stall;
	assign draining_last = out_fire && last;

	// Take a new byte when the result register is free or frees this cycle.
	assign in_stall = !(bundle_empty || draining_last);
	assign in_fire  = in_valid && !in_stall;

	// ------------------------------------------------------------------
	// Decode: one pass over the arriving byte and the held state.
	// ------------------------------------------------------------------
	logic             eot;
	logic             is_cont;
	logic [LEN_W-1:0] held_len, new_len;
	logic [LEN_W-1:0] cnt_plus1;
	cp_t              assembled;

	logic [CNT_W-1:0] nxt_flush;
	logic             nxt_tail_vld;
	cp_t              nxt_tail_cp;
	logic             nxt_tail_sub;
	logic [CNT_W-1:0] nxt_held_cnt;
	logic             wr_en;
	logic [CNT_W-1:0] wr_idx;

	assign eot       = end_of_text || (data_byte == '0);
	assign is_cont   = (data_byte[7:6] == 2'b10);
	assign held_len  = seq_len(held_q[0]);
	assign new_len   = seq_len(data_byte);
	assign cnt_plus1 = LEN_W'(held_cnt_q) + LEN_W'(1);

	// Payload bits of the completed sequence; the final byte supplies the low six.
	always_comb begin
		unique case (held_len)
			LEN_TWO:   assembled = CP_W'({held_q[0][4:0], data_byte[5:0]});
			LEN_THREE: assembled = CP_W'({held_q[0][3:0], held_q[1][5:0],
				data_byte[5:0]});
			default:   assembled = {held_q[0][2:0], held_q[1][5:0], held_q[2][5:0],
				data_byte[5:0]};
		endcase
	end

	always_comb begin
		nxt_flush    = '0;
		nxt_tail_vld = 1'b0;
		nxt_tail_cp  = CP_W'(data_byte);
		nxt_tail_sub = 1'b0;
		nxt_held_cnt = held_cnt_q;
		wr_en        = 1'b0;
		wr_idx       = '0;
		if (eot) begin
			// end of text or a NUL byte: every held byte turns into a replacement
			nxt_flush    = held_cnt_q;
			nxt_held_cnt = '0;
		end else if ((held_cnt_q != '0) && (held_len != LEN_NONE) && is_cont) begin
			if (cnt_plus1 >= held_len) begin
				nxt_tail_vld = 1'b1;
				nxt_tail_cp  = assembled;
				nxt_held_cnt = '0;
			end else begin
				wr_en        = 1'b1;
				wr_idx       = held_cnt_q;
				nxt_held_cnt = CNT_W'(cnt_plus1);
			end
		end else begin
			// broken sequence (if any) is flushed, then the byte is seen afresh
			nxt_flush    = held_cnt_q;
			nxt_held_cnt = '0;
			if (!data_byte[7]) begin
				nxt_tail_vld = 1'b1;
			end else if (new_len != LEN_NONE) begin
				wr_en        = 1'b1;
				wr_idx       = '0;
				nxt_held_cnt = CNT_W'(1);
			end else begin
				nxt_tail_vld = 1'b1;
				nxt_tail_cp  = REPLACEMENT_CP;
				nxt_tail_sub = 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q   <= '0;
			flush_cnt_s1 <= '0;
			tail_vld_s1  <= 1'b0;
		end else begin
			if (in_fire) begin
				held_cnt_q   <= nxt_held_cnt;
				flush_cnt_s1 <= nxt_flush;
				tail_vld_s1  <= nxt_tail_vld;
			end else if (out_fire) begin
				if (flush_cnt_s1 != '0)
					flush_cnt_s1 <= flush_cnt_s1 - CNT_W'(1);
				else
					tail_vld_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			tail_cp_s1  <= nxt_tail_cp;
			tail_sub_s1 <= nxt_tail_sub;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && wr_en) begin
			unique case (wr_idx)
				2'd0:    held_q[0] <= data_byte;
				2'd1:    held_q[1] <= data_byte;
				default: held_q[2] <= data_byte;
			endcase
		end
	end

endmodule
